FILE: design/lpf_pkg.sv
// Shared types and constants for the lookahead path follower.
// Used by the controller, the datapath, the top level and the testbench; depends on nothing.
package lpf_pkg;
	localparam int PATH_DEPTH = 1024;
	localparam int AW = $clog2(PATH_DEPTH);
	localparam int CW = AW + 1;

	localparam logic [1:0] CMD_POINT = 2'd0;
	localparam logic [1:0] CMD_EMPTY = 2'd1;
	localparam logic [1:0] CMD_POSE  = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	localparam logic [2:0] REG_DEFAULT_SPEED = 3'd0;
	localparam logic [2:0] REG_DESIRED_SPEED = 3'd1;
	localparam logic [2:0] REG_GAIN          = 3'd2;
	localparam logic [2:0] REG_LOOKAHEAD     = 3'd3;
	localparam logic [2:0] REG_GOAL_TOL      = 3'd4;
	localparam logic [2:0] REG_REQUEST_DIST  = 3'd5;
	localparam logic [2:0] REG_MODE          = 3'd6;

	localparam logic signed [19:0] ANG_PI      = 20'sd205887;
	localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
	localparam logic signed [20:0] ANG_TWO_PI  = 21'sd411775;
	localparam int CORDIC_STEPS = 16;

	function automatic logic [16:0] atan_entry(input logic [3:0] i);
		case (i)
			4'd0: atan_entry = 17'd51472;
			4'd1: atan_entry = 17'd30386;
			4'd2: atan_entry = 17'd16055;
			4'd3: atan_entry = 17'd8150;
			4'd4: atan_entry = 17'd4091;
			4'd5: atan_entry = 17'd2047;
			4'd6: atan_entry = 17'd1024;
			4'd7: atan_entry = 17'd512;
			4'd8: atan_entry = 17'd256;
			4'd9: atan_entry = 17'd128;
			4'd10: atan_entry = 17'd64;
			4'd11: atan_entry = 17'd32;
			4'd12: atan_entry = 17'd16;
			4'd13: atan_entry = 17'd8;
			4'd14: atan_entry = 17'd4;
			default: atan_entry = 17'd2;
		endcase
	endfunction

	typedef struct packed {
		logic [1:0]   cmd;
		logic [31:0]  pos_x;
		logic [31:0]  pos_y;
		logic [15:0]  heading;
		logic         first_point;
	} in_word_t;

	typedef struct packed {
		logic [15:0]  out_speed;
		logic [15:0]  yaw_rate;
		logic         next_goal;
		logic         stopped;
	} out_word_t;

	typedef struct packed {
		logic [2:0]   index;
		logic [15:0]  value;
	} cfg_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LAST_RD, ST_LAST_WAIT, ST_GOAL_CHK, ST_WALK_RD, ST_WALK_WAIT,
		ST_WALK_CHK, ST_CORDIC, ST_ERR, ST_MUL, ST_OUT, ST_HOLD
	} state_t;

	typedef struct packed {
		logic       rd_last;   // read final waypoint
		logic       rd_idx;    // read waypoint at walk index
		logic       load_diff; // latch offset and distance terms
		logic       sq_step;   // square step
		logic       cordic_init;
		logic       cordic_step;
		logic       err_step;
		logic       mul_step;
	} dp_cmd_t;

	typedef struct packed {
		logic near_req;
		logic near_tol;
		logic near_look;
		logic sq_done;
		logic cordic_done;
	} dp_stat_t;
endpackage

FILE: design/lpf_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface lpf_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/lpf_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module lpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: design/lpf_datapath.sv
// Datapath: waypoint store, distance squares, CORDIC atan2, error and gain.
// Depends on lpf_pkg and lpf_ram.
module lpf_datapath (
	input  logic                     clk,
	input  lpf_pkg::dp_cmd_t         cmd,
	output lpf_pkg::dp_stat_t        stat,
	input  logic                     wp_we,
	input  logic [lpf_pkg::AW-1:0]   wp_waddr,
	input  logic [lpf_pkg::AW-1:0]   last_addr,
	input  logic [lpf_pkg::AW-1:0]   idx_addr,
	input  logic signed [31:0]       wx,
	input  logic signed [31:0]       wy,
	input  logic signed [31:0]       veh_x,
	input  logic signed [31:0]       veh_y,
	input  logic signed [15:0]       veh_yaw,
	input  logic [15:0]              gain,
	input  logic [15:0]              look_dist,
	input  logic [15:0]              tol_dist,
	input  logic [15:0]              req_dist,
	output logic signed [15:0]       yaw_out
);
	logic [lpf_pkg::AW-1:0] addr;
	logic signed [31:0] rx, ry;
	logic signed [32:0] dx_q, dy_q;
	logic [31:0] ax_q, ay_q;
	logic big_q;
	logic [50:0] sum_q;
	logic [1:0] sqc_q;
	logic signed [52:0] cx_q, cy_q;
	logic signed [20:0] z_q;
	logic [4:0] ci_q;
	logic signed [22:0] err_q;
	logic [1:0] ep_q;
	logic signed [39:0] prod_q;
	logic [24:0] sq_in;
	logic [49:0] sqr;
	logic [49:0] tl2, tr2, tq2;
	logic [23:0] tl, tr, tq;
	logic signed [52:0] xs, ys;
	logic signed [40:0] rnd;

	always_comb begin
		if (cmd.rd_last) addr = last_addr;
		else if (cmd.rd_idx) addr = idx_addr;
		else addr = wp_waddr;
	end

	lpf_ram #(.WIDTH(32), .DEPTH(lpf_pkg::PATH_DEPTH)) u_ram_x (
		.clk(clk), .we(wp_we), .addr(addr), .wdata(wx), .rdata(rx));
	lpf_ram #(.WIDTH(32), .DEPTH(lpf_pkg::PATH_DEPTH)) u_ram_y (
		.clk(clk), .we(wp_we), .addr(addr), .wdata(wy), .rdata(ry));

	// one shared squarer: x on the second step, y on the third
	assign sq_in = (sqc_q == 2'd2) ? ay_q[24:0] : ax_q[24:0];
	assign sqr = 50'(sq_in * sq_in);
	assign tl = {look_dist, 8'd0};
	assign tr = {req_dist, 8'd0};
	assign tq = {tol_dist, 8'd0};
	assign tl2 = 50'(tl * tl);
	assign tr2 = 50'(tr * tr);
	assign tq2 = 50'(tq * tq);

	always_ff @(posedge clk) begin
		if (cmd.load_diff) begin
			dx_q <= 33'(rx) - 33'(veh_x);
			dy_q <= 33'(ry) - 33'(veh_y);
			sum_q <= '0;
		end else if (cmd.sq_step) begin
			case (sqc_q)
				2'd0: begin
					ax_q <= dx_q[32] ? 32'(-dx_q) : 32'(dx_q);
					ay_q <= dy_q[32] ? 32'(-dy_q) : 32'(dy_q);
					big_q <= (dx_q >= 33'sh2000000) || (dx_q <= -33'sh2000000)
						|| (dy_q >= 33'sh2000000) || (dy_q <= -33'sh2000000);
				end
				default: sum_q <= sum_q + 51'(sqr);
			endcase
		end
	end

	// step count: abs, add x^2, add y^2, then done
	always_ff @(posedge clk) begin
		if (cmd.load_diff) sqc_q <= '0;
		else if (cmd.sq_step && sqc_q != 2'd3) sqc_q <= sqc_q + 2'd1;
	end

	assign stat.sq_done = (sqc_q == 2'd3);
	assign stat.near_req = !big_q && (sum_q < 51'(tr2));
	assign stat.near_tol = !big_q && (sum_q < 51'(tq2));
	assign stat.near_look = !big_q && (sum_q < 51'(tl2));

	assign xs = cx_q >>> ci_q[3:0];
	assign ys = cy_q >>> ci_q[3:0];

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			if (dx_q == 0 && dy_q == 0) begin
				cx_q <= '0; cy_q <= '0; z_q <= '0;
				ci_q <= 5'(lpf_pkg::CORDIC_STEPS);
			end else begin
				ci_q <= '0;
				if (dx_q[32]) begin
					if (!dy_q[32]) begin
						cx_q <= {{4{dy_q[32]}}, dy_q, 16'd0};
						cy_q <= -{{4{dx_q[32]}}, dx_q, 16'd0};
						z_q <= 21'(lpf_pkg::ANG_HALF_PI);
					end else begin
						cx_q <= -{{4{dy_q[32]}}, dy_q, 16'd0};
						cy_q <= {{4{dx_q[32]}}, dx_q, 16'd0};
						z_q <= -21'(lpf_pkg::ANG_HALF_PI);
					end
				end else begin
					cx_q <= {{4{dx_q[32]}}, dx_q, 16'd0};
					cy_q <= {{4{dy_q[32]}}, dy_q, 16'd0};
					z_q <= '0;
				end
			end
		end else if (cmd.cordic_step && ci_q != 5'(lpf_pkg::CORDIC_STEPS)) begin
			if (!cy_q[52]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				z_q <= z_q + 21'(lpf_pkg::atan_entry(ci_q[3:0]));
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				z_q <= z_q - 21'(lpf_pkg::atan_entry(ci_q[3:0]));
			end
			ci_q <= ci_q + 5'd1;
		end
	end
	assign stat.cordic_done = (ci_q == 5'(lpf_pkg::CORDIC_STEPS));

	// wrap takes at most two corrections
	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			ep_q <= '0;
		end else if (cmd.err_step) begin
			if (ep_q == 2'd0) begin
				err_q <= 23'(z_q) - (23'(veh_yaw) <<< 3);
				ep_q <= 2'd1;
			end else if (err_q > 23'(lpf_pkg::ANG_PI)) begin
				err_q <= err_q - 23'(lpf_pkg::ANG_TWO_PI);
			end else if (err_q < -23'(lpf_pkg::ANG_PI)) begin
				err_q <= err_q + 23'(lpf_pkg::ANG_TWO_PI);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			prod_q <= 40'($signed({1'b0, gain}) * err_q);
		end
	end
	assign rnd = (41'(prod_q) + 41'sd32768) >>> 16;
	assign yaw_out = (rnd > 41'sd32767) ? 16'sh7fff :
		(rnd < -41'sd32768) ? 16'sh8000 : rnd[15:0];
endmodule

FILE: design/lpf_ctrl.sv
// Controller: input decode, path state, tick sequencing, result hold.
// Depends on lpf_pkg.
module lpf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             in_cmd,
	input  logic                   in_first,
	input  logic [7:0]             mode,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_go,
	output logic                   out_req_d,
	output logic                   out_stop_d,
	output lpf_pkg::dp_cmd_t       dcmd,
	input  lpf_pkg::dp_stat_t      stat,
	output logic                   wp_we,
	output logic [lpf_pkg::AW-1:0] wp_waddr,
	output logic [lpf_pkg::AW-1:0] last_addr,
	output logic [lpf_pkg::AW-1:0] idx_addr
);
	lpf_pkg::state_t state_q, state_d;
	logic [lpf_pkg::CW-1:0] count_q;
	logic [lpf_pkg::AW-1:0] tgt_q, walk_q;
	logic valid_q, sent_q, req_q, stop_q, ovalid_q;
	logic [3:0] errc_q;
	logic acc, tick, lastc;

	assign acc = in_valid && in_ready;
	assign tick = acc && in_cmd == lpf_pkg::CMD_TICK && mode >= 8'd2;
	assign wp_we = acc && in_cmd == lpf_pkg::CMD_POINT &&
		(in_first || count_q < lpf_pkg::CW'(lpf_pkg::PATH_DEPTH));
	assign wp_waddr = in_first ? '0 : count_q[lpf_pkg::AW-1:0];
	assign last_addr = lpf_pkg::AW'(count_q - 1'b1);
	assign idx_addr = walk_q;
	assign lastc = (walk_q == last_addr);
	assign out_valid = ovalid_q;
	assign out_req_d = req_q;
	assign out_stop_d = stop_q;
	assign in_ready = (state_q == lpf_pkg::ST_IDLE) && !ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpf_pkg::ST_IDLE;
			count_q <= '0; tgt_q <= '0; walk_q <= '0;
			valid_q <= 1'b0; sent_q <= 1'b0; req_q <= 1'b0; stop_q <= 1'b0;
			ovalid_q <= 1'b0; errc_q <= '0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (acc && in_cmd == lpf_pkg::CMD_POINT) begin
				if (in_first) begin
					count_q <= lpf_pkg::CW'(1); tgt_q <= '0;
					sent_q <= 1'b0; valid_q <= 1'b1;
				end else if (wp_we) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (acc && in_cmd == lpf_pkg::CMD_EMPTY) valid_q <= 1'b0;
			if (tick) begin
				req_q <= 1'b0;
				walk_q <= tgt_q;
			end
			if (state_q == lpf_pkg::ST_GOAL_CHK && stat.sq_done) begin
				if (!sent_q && stat.near_req) begin
					sent_q <= 1'b1; req_q <= 1'b1;
				end
			end
			if (state_q == lpf_pkg::ST_WALK_CHK && stat.sq_done && !lastc
				&& stat.near_look) walk_q <= walk_q + 1'b1;
			if (state_q == lpf_pkg::ST_CORDIC) errc_q <= '0;
			if (state_q == lpf_pkg::ST_ERR) errc_q <= errc_q + 4'd1;
			if (state_d == lpf_pkg::ST_HOLD && state_q != lpf_pkg::ST_HOLD) begin
				ovalid_q <= 1'b1;
				if (state_q == lpf_pkg::ST_OUT) tgt_q <= walk_q;
			end
			if (state_d == lpf_pkg::ST_HOLD && state_q != lpf_pkg::ST_OUT
				&& state_q != lpf_pkg::ST_HOLD) stop_q <= 1'b1;
			else if (state_q == lpf_pkg::ST_IDLE && tick) stop_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		dcmd = '0;
		out_go = 1'b0;
		case (state_q)
			lpf_pkg::ST_IDLE: begin
				if (tick) begin
					if (!valid_q || count_q < lpf_pkg::CW'(2)) state_d = lpf_pkg::ST_HOLD;
					else state_d = lpf_pkg::ST_LAST_RD;
				end
			end
			lpf_pkg::ST_LAST_RD: begin
				dcmd.rd_last = 1'b1;
				state_d = lpf_pkg::ST_LAST_WAIT;
			end
			lpf_pkg::ST_LAST_WAIT: begin
				dcmd.load_diff = 1'b1;
				state_d = lpf_pkg::ST_GOAL_CHK;
			end
			lpf_pkg::ST_GOAL_CHK: begin
				// abs, x^2, y^2 accumulate over three steps
				dcmd.sq_step = !stat.sq_done;
				if (stat.sq_done) begin
					if (stat.near_tol) state_d = lpf_pkg::ST_HOLD;
					else state_d = lpf_pkg::ST_WALK_RD;
				end
			end
			lpf_pkg::ST_WALK_RD: begin
				dcmd.rd_idx = 1'b1;
				state_d = lpf_pkg::ST_WALK_WAIT;
			end
			lpf_pkg::ST_WALK_WAIT: begin
				dcmd.load_diff = 1'b1;
				state_d = lpf_pkg::ST_WALK_CHK;
			end
			lpf_pkg::ST_WALK_CHK: begin
				dcmd.sq_step = !stat.sq_done;
				if (stat.sq_done) begin
					if (!lastc && stat.near_look) state_d = lpf_pkg::ST_WALK_RD;
					else begin
						dcmd.cordic_init = 1'b1;
						state_d = lpf_pkg::ST_CORDIC;
					end
				end
			end
			lpf_pkg::ST_CORDIC: begin
				dcmd.cordic_step = 1'b1;
				if (stat.cordic_done) state_d = lpf_pkg::ST_ERR;
			end
			lpf_pkg::ST_ERR: begin
				dcmd.err_step = 1'b1;
				if (errc_q == 4'd3) state_d = lpf_pkg::ST_MUL;
			end
			lpf_pkg::ST_MUL: begin
				dcmd.mul_step = 1'b1;
				state_d = lpf_pkg::ST_OUT;
			end
			lpf_pkg::ST_OUT: begin
				out_go = 1'b1;
				state_d = lpf_pkg::ST_HOLD;
			end
			lpf_pkg::ST_HOLD: begin
				if (ovalid_q && out_ready) state_d = lpf_pkg::ST_IDLE;
			end
			default: state_d = lpf_pkg::ST_IDLE;
		endcase
	end
endmodule

FILE: design/lookahead_path_follower_top.sv
// Lookahead path follower: a tick yields a command word after walking past the skipped
// waypoints and running CORDIC (skipped for a zero offset), or a stop inside the goal
// tolerance or on a short or cleared path. Input is held until the word is taken, so
// ticks run one at a time; other words are taken every cycle while no tick or command word is outstanding.
// Asynchronous active-low reset clears path, pose and control and sets the registers to their defaults;
// waypoint memory is not cleared.
module lookahead_path_follower_top (
	input logic clk,
	input logic arst_n,
	lpf_if.sink   in_ch,
	lpf_if.source out_ch,
	lpf_if.sink   cfg
);
	logic [15:0] def_spd_q, des_spd_q, gain_q, look_q, tol_q, reqd_q;
	logic [7:0] mode_q;
	logic signed [31:0] vx_q, vy_q;
	logic signed [15:0] vyaw_q;
	logic signed [15:0] yaw_s, yaw_q;
	logic [15:0] spd_q;
	logic go, req_d, stop_d, wp_we;
	logic [lpf_pkg::AW-1:0] waddr, laddr, iaddr;
	lpf_pkg::dp_cmd_t dcmd;
	lpf_pkg::dp_stat_t stat;
	logic in_ready;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_spd_q <= 16'd154; des_spd_q <= 16'd154; gain_q <= 16'd768;
			look_q <= 16'd256; tol_q <= 16'd51; reqd_q <= 16'd256; mode_q <= '0;
			vx_q <= '0; vy_q <= '0; vyaw_q <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					lpf_pkg::REG_DEFAULT_SPEED: def_spd_q <= cfg.data.value[15:0];
					lpf_pkg::REG_DESIRED_SPEED: des_spd_q <= cfg.data.value[15:0];
					lpf_pkg::REG_GAIN:          gain_q <= cfg.data.value[15:0];
					lpf_pkg::REG_LOOKAHEAD:     look_q <= cfg.data.value[15:0];
					lpf_pkg::REG_GOAL_TOL:      tol_q <= cfg.data.value[15:0];
					lpf_pkg::REG_REQUEST_DIST:  reqd_q <= cfg.data.value[15:0];
					lpf_pkg::REG_MODE:          mode_q <= cfg.data.value[7:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ready && in_ch.data.cmd == lpf_pkg::CMD_POSE) begin
				vx_q <= in_ch.data.pos_x; vy_q <= in_ch.data.pos_y;
				vyaw_q <= in_ch.data.heading;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			yaw_q <= yaw_s;
			spd_q <= (des_spd_q != 16'd0) ? des_spd_q : def_spd_q;
		end
	end

	lpf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
		.in_cmd(in_ch.data.cmd), .in_first(in_ch.data.first_point), .mode(mode_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_go(go),
		.out_req_d(req_d), .out_stop_d(stop_d), .dcmd(dcmd), .stat(stat),
		.wp_we(wp_we), .wp_waddr(waddr), .last_addr(laddr), .idx_addr(iaddr)
	);

	lpf_datapath u_dp (
		.clk(clk), .cmd(dcmd), .stat(stat), .wp_we(wp_we), .wp_waddr(waddr),
		.last_addr(laddr), .idx_addr(iaddr), .wx(in_ch.data.pos_x),
		.wy(in_ch.data.pos_y), .veh_x(vx_q), .veh_y(vy_q), .veh_yaw(vyaw_q),
		.gain(gain_q), .look_dist(look_q), .tol_dist(tol_q), .req_dist(reqd_q),
		.yaw_out(yaw_s)
	);

	assign out_ch.data.out_speed = stop_d ? 16'd0 : spd_q;
	assign out_ch.data.yaw_rate = stop_d ? 16'sd0 : yaw_q;
	assign out_ch.data.next_goal = req_d;
	assign out_ch.data.stopped = stop_d;
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for lookahead_path_follower_top: drives path, pose and tick
// words with random gaps and output stalls, and checks each command against a predictor.
// Depends on lpf_pkg, lpf_if and lookahead_path_follower_top from the design folder.
module tb_top;
	localparam int LIMIT = 2000000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpf_if #(.payload_t(lpf_pkg::in_word_t))  in_ch ();
	lpf_if #(.payload_t(lpf_pkg::out_word_t)) out_ch ();
	lpf_if #(.payload_t(lpf_pkg::cfg_word_t)) cfg ();

	lookahead_path_follower_top DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always #4 clk = ~clk;

	// follower model state
	longint     wp_x [lpf_pkg::PATH_DEPTH];
	longint     wp_y [lpf_pkg::PATH_DEPTH];
	int         wp_count = 0;
	int         tgt_idx = 0;
	bit         have_path = 0;
	bit         req_done = 0;
	longint     veh_x = 0, veh_y = 0, veh_yaw = 0;
	logic [15:0] spd_default = 154, spd_desired = 154, gain = 768;
	logic [15:0] look_r = 256, tol_r = 51, req_r = 256;
	logic [7:0]  mode = 0;

	lpf_pkg::in_word_t  pend_q [$];
	lpf_pkg::out_word_t cmd_q [$];
	int         errors = 0;
	int         cycles = 0;
	bit         quiet = 0;
	bit         in_took = 0;
	int         in_gap = 0, out_gap = 0;

	function automatic bit within_r(longint dx, longint dy, logic [15:0] r);
		longint unsigned ax, ay, t;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		t = longint'(r) << 8;
		if (ax >= (64'd1 << 25) || ay >= (64'd1 << 25))
			return 0;
		return ax * ax + ay * ay < t * t;
	endfunction

	function automatic longint bearing(longint dy, longint dx);
		longint x, y, z, t, xs, ys;
		x = dx * 65536;
		y = dy * 65536;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = lpf_pkg::ANG_HALF_PI;
			end else begin
				x = -y; y = t; z = -lpf_pkg::ANG_HALF_PI;
			end
		end
		for (int i = 0; i < lpf_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += lpf_pkg::atan_entry(i[3:0]);
			end else begin
				x -= ys; y += xs; z -= lpf_pkg::atan_entry(i[3:0]);
			end
		end
		return z;
	endfunction

	// Update follower state for one word; return 1 when a command is due.
	function automatic bit follow_word(lpf_pkg::in_word_t w, output lpf_pkg::out_word_t c);
		longint px, py, dx, dy, err, yr;
		int last, idx;
		bit req;
		px = longint'(signed'(w.pos_x));
		py = longint'(signed'(w.pos_y));
		req = 0;
		c = '0;
		case (w.cmd)
			lpf_pkg::CMD_POINT: begin
				if (w.first_point) begin
					wp_count = 0; tgt_idx = 0; req_done = 0; have_path = 1;
				end
				if (wp_count < lpf_pkg::PATH_DEPTH) begin
					wp_x[wp_count] = px;
					wp_y[wp_count] = py;
					wp_count++;
				end
				return 0;
			end
			lpf_pkg::CMD_EMPTY: begin
				have_path = 0;
				return 0;
			end
			lpf_pkg::CMD_POSE: begin
				veh_x = px; veh_y = py;
				veh_yaw = longint'(signed'(w.heading));
				return 0;
			end
			default: ;
		endcase
		if (mode < 2)
			return 0;
		c.stopped = 1;
		if (!have_path || wp_count < 2)
			return 1;
		last = wp_count - 1;
		dx = wp_x[last] - veh_x;
		dy = wp_y[last] - veh_y;
		if (!req_done && within_r(dx, dy, req_r)) begin
			req_done = 1; req = 1;
		end
		c.next_goal = req;
		if (within_r(dx, dy, tol_r))
			return 1;
		idx = tgt_idx;
		while (idx < last && within_r(wp_x[idx] - veh_x, wp_y[idx] - veh_y, look_r))
			idx++;
		if (idx > last)
			idx = last;
		tgt_idx = idx;
		err = bearing(wp_y[idx] - veh_y, wp_x[idx] - veh_x) - veh_yaw * 8;
		while (err > lpf_pkg::ANG_PI) err -= lpf_pkg::ANG_TWO_PI;
		while (err < -lpf_pkg::ANG_PI) err += lpf_pkg::ANG_TWO_PI;
		yr = (longint'(gain) * err + 32768) >>> 16;
		if (yr > 32767) yr = 32767;
		if (yr < -32768) yr = -32768;
		c.stopped = 0;
		c.yaw_rate = yr[15:0];
		c.out_speed = spd_desired != 0 ? spd_desired : spd_default;
		return 1;
	endfunction

	// input driver
	always @(negedge clk) begin
		lpf_pkg::in_word_t nxt;
		logic  v;
		nxt = in_ch.data;
		v = in_ch.valid;
		if (!arst_n) begin
			v = 1'b0;
			nxt = '0;
		end else if (!in_ch.valid || in_took) begin
			v = 1'b0;
			if (in_gap > 0)
				in_gap--;
			else if (!quiet && $urandom_range(0, 7) == 0)
				in_gap = $urandom_range(1, 11) - 1;
			else if (pend_q.size() > 0) begin
				nxt = pend_q.pop_front();
				v = 1'b1;
			end
		end
		in_ch.valid <= v;
		in_ch.data <= nxt;
	end

	// output stall driver
	always @(negedge clk) begin
		logic r;
		r = 1'b1;
		if (!arst_n)
			r = 1'b0;
		else if (out_gap > 0) begin
			out_gap--;
			r = 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(1, 11) - 1;
			r = 1'b0;
		end
		out_ch.ready <= r;
	end

	// monitor: predict accepted words, check commands
	always @(posedge clk) begin
		lpf_pkg::out_word_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
		in_took <= in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (follow_word(in_ch.data, e))
				cmd_q.push_back(e);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (cmd_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected command %p", out_ch.data);
			end else begin
				e = cmd_q.pop_front();
				if (out_ch.data !== e) begin
					errors++;
					if (errors <= 10)
						$display("command mismatch: expected %p, got %p", e, out_ch.data);
				end
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.data = '{index: idx, value: v};
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			lpf_pkg::REG_DEFAULT_SPEED: spd_default = v;
			lpf_pkg::REG_DESIRED_SPEED: spd_desired = v;
			lpf_pkg::REG_GAIN:          gain = v;
			lpf_pkg::REG_LOOKAHEAD:     look_r = v;
			lpf_pkg::REG_GOAL_TOL:      tol_r = v;
			lpf_pkg::REG_REQUEST_DIST:  req_r = v;
			lpf_pkg::REG_MODE:          mode = v[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// wait until every word is in and every command is out
	task automatic drain();
		while (pend_q.size() > 0 || in_ch.valid || cmd_q.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic put(logic [1:0] c, logic [31:0] x, logic [31:0] y,
			logic [15:0] h, logic fp);
		pend_q.push_back('{cmd: c, pos_x: x, pos_y: y, heading: h, first_point: fp});
	endtask

	function automatic logic [15:0] rand_heading();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return 16'($signed($urandom_range(0, 51472)) - 25736);
	endfunction

	// a path, then the vehicle moving along it with ticks
	task automatic path_run(int n, int span);
		int bx, by, x, y, sx, sy;
		bx = $signed($urandom_range(0, 2 * span)) - span;
		by = $signed($urandom_range(0, 2 * span)) - span;
		sx = $signed($urandom_range(0, span)) - span / 2;
		sy = $signed($urandom_range(0, span)) - span / 2;
		for (int i = 0; i < n; i++) begin
			x = bx + i * sx + $signed($urandom_range(0, 4096)) - 2048;
			y = by + i * sy + $signed($urandom_range(0, 4096)) - 2048;
			put(lpf_pkg::CMD_POINT, x, y, 16'($urandom), i == 0);
		end
		for (int k = 0; k <= n; k++) begin
			x = bx + k * sx + $signed($urandom_range(0, span / 2)) - span / 4;
			y = by + k * sy + $signed($urandom_range(0, span / 2)) - span / 4;
			if ($urandom_range(0, 3) != 0)
				put(lpf_pkg::CMD_POSE, x, y, rand_heading(), 1'($urandom));
			put(lpf_pkg::CMD_TICK, $urandom, $urandom, 16'($urandom), 1'($urandom));
			if ($urandom_range(0, 5) == 0)
				put(lpf_pkg::CMD_TICK, $urandom, $urandom, 16'($urandom), 1'($urandom));
		end
	endtask

	task automatic noise_word();
		put(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom), 1'($urandom));
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: mode off, then short path, extremes, goal, zero offset
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		drain();
		reg_write(lpf_pkg::REG_MODE, 16'd2);
		reg_write(lpf_pkg::REG_LOOKAHEAD, 16'd0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_POINT, 0, 0, 0, 1);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_POINT, 32'h0002_0000, 32'h0001_0000, 0, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_POSE, 32'h0001_0000, 32'h0000_8000, 16'h6488, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_POSE, 32'h0002_0000, 32'h0001_4000, 16'h9B78, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_EMPTY, 0, 0, 0, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
		put(lpf_pkg::CMD_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
		put(lpf_pkg::CMD_POINT, 32'hFFFF_0000, 32'h0000_0000, 0, 0);
		put(lpf_pkg::CMD_POSE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_POSE, 0, 0, 16'h8000, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		put(lpf_pkg::CMD_POSE, 32'h8000_0000, 32'h8000_0000, 16'h0000, 0);
		put(lpf_pkg::CMD_TICK, 0, 0, 0, 0);
		drain();

		// random phases across register settings, extremes included
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					for (int r = 0; r < 6; r++)
						reg_write(r[2:0], 16'd0);
					reg_write(lpf_pkg::REG_MODE, 16'd255);
				end
				1: begin
					for (int r = 0; r < 6; r++)
						reg_write(r[2:0], 16'hFFFF);
					reg_write(lpf_pkg::REG_MODE, 16'd3);
				end
				2: reg_write(lpf_pkg::REG_MODE, 16'd1);
				default: begin
					reg_write(lpf_pkg::REG_DEFAULT_SPEED, 16'($urandom));
					reg_write(lpf_pkg::REG_DESIRED_SPEED,
						$urandom_range(0, 1) ? 16'd0 : 16'($urandom));
					reg_write(lpf_pkg::REG_GAIN, 16'($urandom_range(0, 4096)));
					reg_write(lpf_pkg::REG_LOOKAHEAD, 16'($urandom_range(0, 1024)));
					reg_write(lpf_pkg::REG_GOAL_TOL, 16'($urandom_range(0, 256)));
					reg_write(lpf_pkg::REG_REQUEST_DIST, 16'($urandom_range(0, 1536)));
					reg_write(lpf_pkg::REG_MODE, 16'($urandom_range(2, 255)));
					reg_write(REG_UNUSED, 16'($urandom));
				end
			endcase
			quiet = (ph == 9);
			while (pend_q.size() < 30) begin
				if ($urandom_range(0, 4) == 0)
					noise_word();
				else
					path_run($urandom_range(2, 10),
						$urandom_range(0, 3) == 0 ? 32'h0010_0000 : 32'h0002_0000);
			end
			drain();
		end

		if (errors == 0 && cmd_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
